// File: rtl/core/ptc_pkg.sv
// shared types and constants for the pwm tone period and duty calculator
package ptc_pkg;

  localparam int TICK_W   = 32;
  localparam int DUTY_W   = 10;
  localparam int PER_W    = TICK_W + 1;
  localparam int DVD_W    = TICK_W + DUTY_W;
  localparam int DVD_PAD  = DVD_W - PER_W;
  localparam int CNT_W    = $clog2(DVD_W + 1);
  localparam int DIV1_STEPS = PER_W;
  localparam int DIV2_STEPS = DVD_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TICK_W-1:0] TICK_RATE_RST  = TICK_W'(1000000);
  localparam logic [TICK_W-1:0] MAX_PERIOD_RST = TICK_W'(65536);
  localparam logic [TICK_W-1:0] MIN_PERIOD     = TICK_W'(2);
  localparam logic [DUTY_W-1:0] DUTY_MAX       = DUTY_W'(999);
  localparam logic [TICK_W-1:0] DUTY_DEN       = TICK_W'(1000);
  localparam logic [DVD_W-1:0]  DUTY_HALF      = DVD_W'(500);

  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_STOP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = CFG_IDX_W'(1);

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_CHECK,
    S_MUL,
    S_DIV2,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              status;
    logic [TICK_W-1:0] reload_value;
    logic [TICK_W-1:0] compare_value;
    logic              load_timer;
    logic              start_pulse;
    logic              stop_pulse;
  } result_t;

endpackage

// File: rtl/core/ptc_in_if.sv
// request channel of the pwm tone calculator
interface ptc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ptc_pkg::TICK_W-1:0]   tone_hz;
  logic [ptc_pkg::DUTY_W-1:0]   duty;

  modport source (output valid, output mode, output tone_hz, output duty,
                  input ready);
  modport sink   (input valid, input mode, input tone_hz, input duty,
                  output ready);
endinterface

// File: rtl/core/ptc_out_if.sv
// result channel of the pwm tone calculator
interface ptc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [ptc_pkg::TICK_W-1:0]   reload_value;
  logic [ptc_pkg::TICK_W-1:0]   compare_value;
  logic                         load_timer;
  logic                         start_pulse;
  logic                         stop_pulse;

  modport source (output valid, output status, output reload_value, output compare_value,
                  output load_timer, output start_pulse, output stop_pulse,
                  input ready);
  modport sink   (input valid, input status, input reload_value, input compare_value,
                  input load_timer, input start_pulse, input stop_pulse,
                  output ready);
  modport mon    (input valid, input ready, input status, input reload_value,
                  input compare_value, input load_timer, input start_pulse,
                  input stop_pulse);
endinterface

// File: rtl/core/pwm_tone_period_duty_calc_top.sv
// pwm tone calculator: request in, timer reload and compare settings out
// result: a stop, a bad duty or a zero tone shows its result in the cycle after acceptance,
//   a period out of range after S_DIV1, S_CHECK; a valid set request after S_DIV1 to S_FIN
// flow: one request at a time, the next is taken the cycle after the result is taken,
//   a set request runs the shared restoring divider twice (33 + 42 steps)
// reset (synchronous, rst_n low): idle, tone not running, registers to 1000000 / 65536
module pwm_tone_period_duty_calc_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ptc_in_if.sink                          in_ch,
  ptc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ptc_pkg::TICK_W-1:0]      cfg_wdata
);

  // control state
  ptc_pkg::state_t state_r, state_nxt;
  logic            running_r;
  logic [ptc_pkg::CNT_W-1:0] cnt_r;

  // configuration registers
  logic [ptc_pkg::TICK_W-1:0] tick_rate_r;
  logic [ptc_pkg::TICK_W-1:0] max_period_r;

  // datapath registers of the shared divider
  // dvd_r holds the dividend left-aligned; quotient bits shift in at the bottom
  logic [ptc_pkg::DVD_W-1:0]  dvd_r;
  logic [ptc_pkg::TICK_W-1:0] rem_r;
  logic [ptc_pkg::TICK_W-1:0] divisor_r;
  logic [ptc_pkg::TICK_W-1:0] period_r;
  logic [ptc_pkg::DUTY_W-1:0] duty_r;
  ptc_pkg::result_t           res_r;

  // handshake
  logic in_ready;
  logic out_valid;
  logic accept;
  logic req_stop;
  logic req_bad;

  // divider step
  logic [ptc_pkg::TICK_W:0]   rem_shift;
  logic [ptc_pkg::TICK_W+1:0] rem_diff;
  logic                       q_bit;
  logic [ptc_pkg::TICK_W-1:0] rem_step;
  logic [ptc_pkg::DVD_W-1:0]  dvd_step;
  logic                       div1_last;
  logic                       div2_last;

  // period range check
  logic [ptc_pkg::PER_W-1:0]  per_q;
  logic [ptc_pkg::TICK_W-1:0] per_limit;
  logic                       per_bad;

  // rounded period dividend and duty product
  logic [ptc_pkg::PER_W-1:0]  per_dividend;
  logic [ptc_pkg::DVD_W-1:0]  duty_prod;

  // final compare clamp
  logic [ptc_pkg::TICK_W-1:0] cmp_final;

  assign accept   = in_ch.valid && in_ready;
  assign req_stop = (in_ch.mode == ptc_pkg::MODE_STOP);
  assign req_bad  = (in_ch.duty == '0) || (in_ch.duty > ptc_pkg::DUTY_MAX)
                    || (in_ch.tone_hz == '0);

  // one restoring step: shift in the next dividend bit, try subtracting the divisor
  assign rem_shift = {rem_r, dvd_r[ptc_pkg::DVD_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_r};
  assign q_bit     = !rem_diff[ptc_pkg::TICK_W+1];
  assign rem_step  = q_bit ? rem_diff[ptc_pkg::TICK_W-1:0] : rem_shift[ptc_pkg::TICK_W-1:0];
  assign dvd_step  = {dvd_r[ptc_pkg::DVD_W-2:0], q_bit};

  assign div1_last = (cnt_r == ptc_pkg::CNT_W'(ptc_pkg::DIV1_STEPS - 1));
  assign div2_last = (cnt_r == ptc_pkg::CNT_W'(ptc_pkg::DIV2_STEPS - 1));

  // period = (tick_rate + tone/2) / tone, always below 2^32
  assign per_dividend = {1'b0, tick_rate_r} + {2'b00, in_ch.tone_hz[ptc_pkg::TICK_W-1:1]};
  assign per_q        = dvd_r[ptc_pkg::PER_W-1:0];
  // a maximum below 2 acts as 2
  assign per_limit    = (max_period_r < ptc_pkg::MIN_PERIOD) ? ptc_pkg::MIN_PERIOD
                                                             : max_period_r;
  assign per_bad      = (per_q < {1'b0, ptc_pkg::MIN_PERIOD}) || (per_q > {1'b0, per_limit});

  // compare = (period * duty + 500) / 1000
  assign duty_prod = ptc_pkg::DVD_W'(period_r) * ptc_pkg::DVD_W'(duty_r) + ptc_pkg::DUTY_HALF;

  // clamp the rounded compare into 1 .. period-1
  always_comb begin
    priority if (dvd_r == '0) begin
      cmp_final = ptc_pkg::TICK_W'(1);
    end else if (dvd_r >= ptc_pkg::DVD_W'(period_r)) begin
      cmp_final = period_r - ptc_pkg::TICK_W'(1);
    end else begin
      cmp_final = dvd_r[ptc_pkg::TICK_W-1:0];
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (req_stop || req_bad) ? ptc_pkg::S_OUT : ptc_pkg::S_DIV1;
        end
      end
      ptc_pkg::S_DIV1: begin
        if (div1_last) state_nxt = ptc_pkg::S_CHECK;
      end
      ptc_pkg::S_CHECK: begin
        state_nxt = per_bad ? ptc_pkg::S_OUT : ptc_pkg::S_MUL;
      end
      ptc_pkg::S_MUL: begin
        state_nxt = ptc_pkg::S_DIV2;
      end
      ptc_pkg::S_DIV2: begin
        if (div2_last) state_nxt = ptc_pkg::S_FIN;
      end
      ptc_pkg::S_FIN: begin
        state_nxt = ptc_pkg::S_OUT;
      end
      ptc_pkg::S_OUT: begin
        if (out_ch.ready) state_nxt = ptc_pkg::S_IDLE;
      end
      default: state_nxt = ptc_pkg::S_IDLE;
    endcase
  end

  // sequencer: handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ptc_pkg::S_IDLE: in_ready  = 1'b1;
      ptc_pkg::S_OUT:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptc_pkg::S_IDLE;
      running_r    <= 1'b0;
      cnt_r        <= '0;
      tick_rate_r  <= ptc_pkg::TICK_RATE_RST;
      max_period_r <= ptc_pkg::MAX_PERIOD_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_idx)
          ptc_pkg::CFG_TICK_RATE:  tick_rate_r  <= cfg_wdata;
          ptc_pkg::CFG_MAX_PERIOD: max_period_r <= cfg_wdata;
          default: ;
        endcase
      end

      // step counter runs through both divisions
      if (state_r == ptc_pkg::S_DIV1 || state_r == ptc_pkg::S_DIV2) begin
        cnt_r <= cnt_r + ptc_pkg::CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end

      // a stop clears the tone, a good set starts it, errors leave it alone
      if (state_r == ptc_pkg::S_IDLE && accept && req_stop) begin
        running_r <= 1'b0;
      end else if (state_r == ptc_pkg::S_FIN) begin
        running_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ptc_pkg::S_IDLE: begin
        divisor_r <= in_ch.tone_hz;
        duty_r    <= in_ch.duty;
        dvd_r     <= {per_dividend, ptc_pkg::DVD_PAD'(0)};
        rem_r     <= '0;
        if (req_stop) begin
          res_r <= '{status: ptc_pkg::ST_OK, reload_value: '0, compare_value: '0,
                     load_timer: 1'b0, start_pulse: 1'b0, stop_pulse: running_r};
        end else begin
          res_r <= '{status: ptc_pkg::ST_ERR, reload_value: '0, compare_value: '0,
                     load_timer: 1'b0, start_pulse: 1'b0, stop_pulse: 1'b0};
        end
      end
      ptc_pkg::S_DIV1, ptc_pkg::S_DIV2: begin
        dvd_r <= dvd_step;
        rem_r <= rem_step;
      end
      ptc_pkg::S_CHECK: begin
        period_r <= per_q[ptc_pkg::TICK_W-1:0];
        res_r    <= '{status: ptc_pkg::ST_ERR, reload_value: '0, compare_value: '0,
                      load_timer: 1'b0, start_pulse: 1'b0, stop_pulse: 1'b0};
      end
      ptc_pkg::S_MUL: begin
        dvd_r     <= duty_prod;
        rem_r     <= '0;
        divisor_r <= ptc_pkg::DUTY_DEN;
      end
      ptc_pkg::S_FIN: begin
        res_r <= '{status: ptc_pkg::ST_OK,
                   reload_value: period_r - ptc_pkg::TICK_W'(1),
                   compare_value: cmp_final,
                   load_timer: 1'b1, start_pulse: !running_r, stop_pulse: 1'b0};
      end
      ptc_pkg::S_OUT: ;
      default: ;
    endcase
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.status        = res_r.status;
  assign out_ch.reload_value  = res_r.reload_value;
  assign out_ch.compare_value = res_r.compare_value;
  assign out_ch.load_timer    = res_r.load_timer;
  assign out_ch.start_pulse   = res_r.start_pulse;
  assign out_ch.stop_pulse    = res_r.stop_pulse;

endmodule

// File: rtl/core/ptc_checker.sv
// port-level checks for the pwm tone calculator, bound to the top level
module ptc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_status,
  input logic [ptc_pkg::TICK_W-1:0] out_reload_value,
  input logic [ptc_pkg::TICK_W-1:0] out_compare_value,
  input logic                       out_load_timer,
  input logic                       out_start_pulse,
  input logic                       out_stop_pulse
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an error changes nothing on the timer
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ptc_pkg::ST_ERR) |->
      !out_load_timer && !out_start_pulse && !out_stop_pulse)
    else $error("error result touches the timer");

  // start and stop never come together
  a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_start_pulse && out_stop_pulse))
    else $error("start and stop in one result");

  // a loaded compare lies within 1 .. period-1
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_timer |->
      (out_compare_value != '0) && (out_compare_value <= out_reload_value))
    else $error("compare outside the period");

endmodule

bind pwm_tone_period_duty_calc_top ptc_checker u_ptc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_reload_value  (out_ch.reload_value),
  .out_compare_value (out_ch.compare_value),
  .out_load_timer    (out_ch.load_timer),
  .out_start_pulse   (out_ch.start_pulse),
  .out_stop_pulse    (out_ch.stop_pulse)
);
